// ===== rtl/core/bole_pkg.sv =====
package bole_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int COUNT_W  = 5;
  localparam int VALUE_W  = 32;
  localparam int ACTION_W = 3;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [COUNT_W-1:0]        count_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND_BACK   = 3'd0,
    ACT_INSERT_FRONT  = 3'd1,
    ACT_INSERT_B_LAST = 3'd2,
    ACT_INSERT_B_POS  = 3'd3,
    ACT_DELETE_FRONT  = 3'd4,
    ACT_DELETE_BACK   = 3'd5,
    ACT_READ          = 3'd6
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    cell_op_t op;
    idx_t     idx;
    value_t   value;
  } cell_cmd_t;

endpackage

// ===== rtl/core/bole_if.sv =====
interface bole_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [bole_pkg::ACTION_W-1:0]         action;
  logic signed [bole_pkg::VALUE_W-1:0]   item_value;
  logic [bole_pkg::POS_W-1:0]            position;

  modport source (output valid, output action, output item_value, output position,
                  input ready);
  modport sink   (input valid, input action, input item_value, input position,
                  output ready);
endinterface

interface bole_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [bole_pkg::STATUS_W-1:0]         status;
  logic [bole_pkg::COUNT_W-1:0]          element_count;
  logic signed [bole_pkg::VALUE_W-1:0]   read_value;

  modport source (output valid, output status, output element_count, output read_value,
                  input ready);
  modport sink   (input valid, input status, input element_count, input read_value,
                  output ready);
endinterface

// ===== rtl/core/bole_cell.sv =====
module bole_cell (
  input  logic                clk,
  input  bole_pkg::cell_cmd_t cmd,
  input  bole_pkg::idx_t      cell_index,
  input  bole_pkg::value_t    left_value,
  input  bole_pkg::value_t    right_value,
  output bole_pkg::value_t    value,
  output bole_pkg::value_t    tap
);
  import bole_pkg::*;

  value_t value_next;

  always_comb begin
    value_next = value;
    unique case (cmd.op)
      CELL_INSERT: begin
        if (cell_index == cmd.idx) begin
          value_next = cmd.value;
        end else if (cell_index > cmd.idx) begin
          value_next = left_value;
        end
      end
      CELL_DELETE: begin
        // close the gap: take from the right neighbor
        if (cell_index >= cmd.idx) begin
          value_next = right_value;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign tap = (cell_index == cmd.idx) ? value : '0;

endmodule

// ===== rtl/core/bounded_ordered_list_engine_unit.sv =====
// Bounded ordered list engine.
// req channel: one operation per transfer (action, item_value, position).
// rsp channel: exactly one result per operation (status, element_count,
// read_value), in order.
// The list lives in a row of CAPACITY cells; every cell sees the decoded
// operation, and the cells at or past its index shift toward or away
// from a neighbor, so an operation completes in the cycle it is accepted.
// The result is registered and valid in the cycle after the request transfer.
// Throughput: one operation per cycle while rsp is taken every cycle; the
// single output register sets that figure.
// Stall: while a result waits and rsp.ready is low, req.ready is low and
// the list holds. A new request is taken in the cycle the waiting result
// transfers.
// Reset (rst, synchronous): the element count clears to zero and no result
// is pending; cell contents are not cleared and are never read before
// being written.
module bounded_ordered_list_engine_unit (
  input logic      clk,
  input logic      rst,
  bole_req_if.sink req,
  bole_rsp_if.source rsp
);
  import bole_pkg::*;

  count_t    fill_count;
  count_t    fill_count_next;
  cell_cmd_t cmd;
  status_t   status_next;
  logic      take_tap;
  logic      accept;
  logic      pos_ok;
  value_t    tap_or;
  value_t    cell_value [CAPACITY];
  value_t    cell_tap   [CAPACITY];

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign pos_ok = (req.position != '0) && (COUNT_W'(req.position) <= fill_count);

  always_comb begin
    cmd.op          = CELL_HOLD;
    cmd.idx         = '0;
    cmd.value       = req.item_value;
    status_next     = ST_OK;
    take_tap        = 1'b0;
    fill_count_next = fill_count;
    unique case (req.action) inside
      ACT_APPEND_BACK, ACT_INSERT_FRONT, ACT_INSERT_B_LAST, ACT_INSERT_B_POS: begin
        if (fill_count == COUNT_W'(CAPACITY)) begin
          status_next = ST_FULL;
        end else if (req.action == ACT_APPEND_BACK) begin
          cmd.op  = CELL_INSERT;
          cmd.idx = fill_count[IDX_W-1:0];
        end else if (req.action == ACT_INSERT_FRONT || fill_count == '0) begin
          cmd.op  = CELL_INSERT;
          cmd.idx = '0;
        end else if (req.action == ACT_INSERT_B_LAST) begin
          cmd.op  = CELL_INSERT;
          cmd.idx = IDX_W'(fill_count - 1'b1);
        end else if (!pos_ok) begin
          status_next = ST_RANGE;
        end else begin
          cmd.op  = CELL_INSERT;
          cmd.idx = IDX_W'(req.position - 1'b1);
        end
        if (cmd.op == CELL_INSERT) begin
          fill_count_next = fill_count + 1'b1;
        end
      end
      ACT_DELETE_FRONT, ACT_DELETE_BACK, ACT_READ: begin
        if (fill_count == '0) begin
          status_next = ST_EMPTY;
        end else if (req.action == ACT_DELETE_FRONT) begin
          cmd.op   = CELL_DELETE;
          cmd.idx  = '0;
          take_tap = 1'b1;
        end else if (req.action == ACT_DELETE_BACK) begin
          cmd.op   = CELL_DELETE;
          cmd.idx  = IDX_W'(fill_count - 1'b1);
          take_tap = 1'b1;
        end else if (!pos_ok) begin
          status_next = ST_RANGE;
        end else begin
          cmd.idx  = IDX_W'(req.position - 1'b1);
          take_tap = 1'b1;
        end
        if (cmd.op == CELL_DELETE) begin
          fill_count_next = fill_count - 1'b1;
        end
      end
      default: status_next = ST_OK;
    endcase
    // cells move only on a transfer
    if (!accept) begin
      cmd.op = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t left_value;
    value_t right_value;
    if (i == 0) begin : g_first
      assign left_value = '0;
    end else begin : g_left
      assign left_value = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_right
      assign right_value = cell_value[i+1];
    end
    bole_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .cell_index  (IDX_W'(i)),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_value[i]),
      .tap         (cell_tap[i])
    );
  end

  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      if (accept) begin
        fill_count <= fill_count_next;
        rsp.valid  <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status        <= status_next;
      rsp.element_count <= fill_count_next;
      rsp.read_value    <= take_tap ? tap_or : '0;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bole_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_OPS  = 640;
  localparam int TABLE_ROWS  = 25;
  localparam int MAX_PRINTS  = 50;

  // Action code the block decodes to nothing.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
  localparam value_t VMAX = 32'sh7FFF_FFFF;
  localparam value_t VMIN = 32'sh8000_0000;

  typedef struct packed {
    status_t st;
    count_t  cnt;
    value_t  rv;
  } list_result_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    value_t              v;
    logic [POS_W-1:0]    pos;
    logic [4:0]          reps;
    logic                typed;
    list_result_t        res;
  } op_row_t;

  typedef enum logic [1:0] {PH_GROW, PH_SHRINK, PH_MIX} load_phase_t;

  localparam list_result_t NO_CHECK = '{ST_OK, 5'd0, 32'sd0};

  logic clk;
  logic rst;

  bole_req_if req_ch ();
  bole_rsp_if rsp_ch ();

  bounded_ordered_list_engine_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the list contents.
  value_t       list_vals [CAPACITY];
  int           list_len = 0;
  list_result_t pending_results [$];

  op_row_t op_table [TABLE_ROWS];

  int mismatch_count = 0;
  int results_checked = 0;
  int ops_sent = 0;
  int cycle_count = 0;
  int status_hits [4] = '{0, 0, 0, 0};
  int drv_left = 0;
  bit drv_steady = 1'b0;
  int rcv_left = 0;
  bit rcv_steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS)
      $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Runs of zero wait mix with runs of random waits; each run's kind is drawn at random.
  function automatic int draw_wait(inout int stretch_left, inout bit steady);
    if (stretch_left == 0) begin
      stretch_left = $urandom_range(5, 40);
      steady = ($urandom_range(0, 2) == 0);
    end
    stretch_left--;
    return steady ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic void apply_list_op(input logic [ACTION_W-1:0] act, input value_t v,
                                        input logic [POS_W-1:0] pos,
                                        output list_result_t res);
    int slot;
    int n;
    n = list_len;
    slot = -1;
    res.st = ST_OK;
    res.rv = '0;
    if (act <= ACT_INSERT_B_POS) begin
      // Full check wins; an empty list takes every insert at the front.
      if (n >= CAPACITY) res.st = ST_FULL;
      else if (act == ACT_APPEND_BACK) slot = n;
      else if (act == ACT_INSERT_FRONT || n == 0) slot = 0;
      else if (act == ACT_INSERT_B_LAST) slot = n - 1;
      else if (pos == 0 || pos > n) res.st = ST_RANGE;
      else slot = pos - 1;
      if (slot >= 0) begin
        for (int i = n; i > slot; i--) list_vals[i] = list_vals[i-1];
        list_vals[slot] = v;
        list_len++;
      end
    end else if (act <= ACT_READ) begin
      if (n == 0) begin
        res.st = ST_EMPTY;
      end else if (act == ACT_READ) begin
        if (pos == 0 || pos > n) res.st = ST_RANGE;
        else res.rv = list_vals[pos-1];
      end else begin
        slot = (act == ACT_DELETE_FRONT) ? 0 : n - 1;
        res.rv = list_vals[slot];
        for (int i = slot; i + 1 < n; i++) list_vals[i] = list_vals[i+1];
        list_len--;
      end
    end
    res.cnt = count_t'(list_len);
  endfunction

  task automatic send_op(input logic [ACTION_W-1:0] act, input value_t v,
                         input logic [POS_W-1:0] pos, input logic typed,
                         input list_result_t typed_res);
    int gap;
    list_result_t res;
    gap = draw_wait(drv_left, drv_steady);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.item_value <= v;
    req_ch.position   <= pos;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    apply_list_op(act, v, pos, res);
    pending_results.push_back(typed ? typed_res : res);
    status_hits[res.st]++;
    ops_sent++;
  endtask

  // Result side: random stalls, check every transfer against the oldest entry.
  initial begin
    int stall;
    list_result_t want;
    rsp_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = draw_wait(rcv_left, rcv_steady);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no operation pending");
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.st)
          report_mismatch($sformatf("status %0d, want %0d", rsp_ch.status, want.st));
        if (rsp_ch.element_count !== want.cnt)
          report_mismatch($sformatf("element_count %0d, want %0d",
                                    rsp_ch.element_count, want.cnt));
        if (rsp_ch.read_value !== want.rv)
          report_mismatch($sformatf("read_value %h, want %h", rsp_ch.read_value, want.rv));
      end
    end
  end

  initial begin
    load_phase_t         phase;
    int                  phase_left;
    int                  random_ops;
    int                  r;
    int                  hi;
    int                  ins_pct;
    int                  del_pct;
    logic [ACTION_W-1:0] act;
    value_t              v;
    logic [POS_W-1:0]    pos;

    op_table = '{
      // empty list: deletes and reads report empty
      '{ACT_READ,          32'sd0,         5'd1,  5'd1,  1'b1, '{ST_EMPTY, 5'd0,  32'sd0}},
      '{ACT_DELETE_FRONT,  32'sd0,         5'd0,  5'd1,  1'b1, '{ST_EMPTY, 5'd0,  32'sd0}},
      '{ACT_DELETE_BACK,   32'sd0,         5'd31, 5'd1,  1'b1, '{ST_EMPTY, 5'd0,  32'sd0}},
      // insert before a wild position on an empty list lands at the front
      '{ACT_INSERT_B_POS,  VMAX,           5'd31, 5'd1,  1'b1, '{ST_OK,    5'd1,  32'sd0}},
      '{ACT_READ,          32'sd0,         5'd1,  5'd1,  1'b1, '{ST_OK,    5'd1,  VMAX}},
      '{ACT_READ,          32'sd0,         5'd0,  5'd1,  1'b1, '{ST_RANGE, 5'd1,  32'sd0}},
      '{ACT_READ,          32'sd0,         5'd2,  5'd1,  1'b1, '{ST_RANGE, 5'd1,  32'sd0}},
      // before-last with a single element goes to the front
      '{ACT_INSERT_B_LAST, VMIN,           5'd5,  5'd1,  1'b1, '{ST_OK,    5'd2,  32'sd0}},
      '{ACT_READ,          32'sd0,         5'd1,  5'd1,  1'b1, '{ST_OK,    5'd2,  VMIN}},
      '{ACT_INSERT_B_POS,  32'sd123,       5'd0,  5'd1,  1'b1, '{ST_RANGE, 5'd2,  32'sd0}},
      '{ACT_INSERT_B_POS,  32'sd123,       5'd3,  5'd1,  1'b1, '{ST_RANGE, 5'd2,  32'sd0}},
      '{ACT_APPEND_BACK,   32'sd1,         5'd0,  5'd1,  1'b0, NO_CHECK},
      '{ACT_INSERT_FRONT,  -32'sd1,        5'd0,  5'd1,  1'b0, NO_CHECK},
      '{ACT_INSERT_B_POS,  32'sh5A5A_5A5A, 5'd2,  5'd1,  1'b0, NO_CHECK},
      '{ACT_UNUSED,        -32'sd1,        5'd31, 5'd1,  1'b1, '{ST_OK,    5'd5,  32'sd0}},
      '{ACT_INSERT_B_LAST, 32'sh1234_5678, 5'd16, 5'd1,  1'b0, NO_CHECK},
      '{ACT_APPEND_BACK,   32'sh0A5A_0000, 5'd0,  5'd10, 1'b0, NO_CHECK},
      // full: every insert is refused, the full check comes before range
      '{ACT_APPEND_BACK,   32'sd7,         5'd0,  5'd1,  1'b1, '{ST_FULL,  5'd16, 32'sd0}},
      '{ACT_INSERT_FRONT,  32'sd7,         5'd0,  5'd1,  1'b1, '{ST_FULL,  5'd16, 32'sd0}},
      '{ACT_INSERT_B_LAST, 32'sd7,         5'd0,  5'd1,  1'b1, '{ST_FULL,  5'd16, 32'sd0}},
      '{ACT_INSERT_B_POS,  32'sd7,         5'd1,  5'd1,  1'b1, '{ST_FULL,  5'd16, 32'sd0}},
      '{ACT_READ,          32'sd0,         5'd16, 5'd1,  1'b0, NO_CHECK},
      '{ACT_READ,          32'sd0,         5'd17, 5'd1,  1'b1, '{ST_RANGE, 5'd16, 32'sd0}},
      '{ACT_DELETE_BACK,   32'sd0,         5'd0,  5'd2,  1'b0, NO_CHECK},
      '{ACT_DELETE_FRONT,  32'sd0,         5'd0,  5'd14, 1'b0, NO_CHECK}
    };

    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.action     <= ACT_APPEND_BACK;
    req_ch.item_value <= '0;
    req_ch.position   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (op_table[i])
      for (int k = 0; k < op_table[i].reps; k++)
        send_op(op_table[i].act, op_table[i].v + k, op_table[i].pos,
                op_table[i].typed, op_table[i].res);

    // Random part: phases that drive the list toward full, toward empty, or churn it.
    phase = PH_MIX;
    phase_left = 0;
    random_ops = 0;
    while (random_ops < RANDOM_OPS) begin
      if (phase_left == 0) begin
        phase = load_phase_t'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      case (phase)
        PH_GROW: begin
          ins_pct = 75;
          del_pct = 10;
        end
        PH_SHRINK: begin
          ins_pct = 12;
          del_pct = 70;
        end
        default: begin
          ins_pct = 40;
          del_pct = 35;
        end
      endcase

      r = $urandom_range(0, 99);
      if (r < ins_pct)
        act = ACTION_W'($urandom_range(ACT_APPEND_BACK, ACT_INSERT_B_POS));
      else if (r < ins_pct + del_pct)
        act = ACTION_W'($urandom_range(ACT_DELETE_FRONT, ACT_DELETE_BACK));
      else if (r < 98) act = ACT_READ;
      else act = ACT_UNUSED;

      hi = (list_len > 0) ? list_len : 1;
      r = $urandom_range(0, 9);
      if (r < 7) pos = POS_W'($urandom_range(1, hi));
      else if (r == 7) pos = '0;
      else if (r == 8) pos = POS_W'(list_len + 1);
      else pos = POS_W'($urandom_range(0, 31));

      r = $urandom_range(0, 9);
      if (r < 6) v = $urandom;
      else if (r == 6) v = VMAX;
      else if (r == 7) v = VMIN;
      else if (r == 8) v = '0;
      else v = int'($urandom_range(0, 15)) - 8;

      send_op(act, v, pos, 1'b0, NO_CHECK);
      if (act != ACT_UNUSED) random_ops++;
    end
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("%0d operations sent (%0d random), %0d results checked, %0d mismatches",
             ops_sent, random_ops, results_checked, mismatch_count);
    $display("outcomes seen: ok %0d, full %0d, empty %0d, out of range %0d",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_RANGE]);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== bounded_ordered_list_engine_unit.f =====
rtl/core/bole_pkg.sv
rtl/core/bole_if.sv
rtl/core/bole_cell.sv
rtl/core/bounded_ordered_list_engine_unit.sv
tb/tb_top.sv
